### rtl/sst_pkg.sv
// shared constants, register codes and types of the stepped sweep tone generator
package sst_pkg;

    // sine table address and phase accumulator widths
    localparam int SINE_ADDR_BITS = 8;
    localparam int PHASE_BITS     = 32;

    // quarter-wave position in Q16 spans 0..1.0, so 17 bits
    localparam int X_W     = 17;
    localparam int X_SHIFT = 18 - SINE_ADDR_BITS;
    localparam logic [SINE_ADDR_BITS-2:0] SINE_QUARTER =
        {1'b1, {(SINE_ADDR_BITS-2){1'b0}}};

    // horner coefficients of sin(pi/2 * x), Q16
    localparam logic [X_W-1:0] SINE_C0 = 17'd102944;
    localparam logic [X_W-1:0] SINE_C1 = 17'd42334;
    localparam logic [X_W-1:0] SINE_C2 = 17'd5223;
    localparam logic [X_W-1:0] SINE_C3 = 17'd307;

    // serial multiplier widths
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_STEP   = 3'd0,
        REG_TOP_STEP     = 3'd1,
        REG_BOTTOM_STEP  = 3'd2,
        REG_UP_RATIO     = 3'd3,
        REG_DOWN_RATIO   = 3'd4,
        REG_NOTE_LENGTH  = 3'd5,
        REG_VOLUME       = 3'd6,
        REG_SWEEP_ENABLE = 3'd7
    } reg_idx_t;

    // register reset values
    localparam logic [30:0] START_STEP_RST  = 31'd22906492;
    localparam logic [30:0] TOP_STEP_RST    = 31'd91625969;
    localparam logic [30:0] BOTTOM_STEP_RST = 31'd22906492;
    localparam logic [17:0] UP_RATIO_RST    = 18'd91750;
    localparam logic [16:0] DOWN_RATIO_RST  = 17'd46811;
    localparam logic [15:0] NOTE_LENGTH_RST = 16'd3200;
    localparam logic [15:0] VOLUME_RST      = 16'd6554;

    typedef struct packed {
        logic [30:0] start_step;
        logic [30:0] top_step;
        logic [30:0] bottom_step;
        logic [17:0] up_ratio;
        logic [16:0] down_ratio;
        logic [15:0] note_length;
        logic [15:0] volume;
        logic        sweep_enable;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] p;
    } mul_rsp_t;

endpackage

### rtl/sst_cfg_regs.sv
// configuration register file of the tone generator
module sst_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sst_pkg::CFG_DATA_W-1:0]   cfg_data,
    output sst_pkg::cfg_t                    cfg
);

    sst_pkg::cfg_t cfg_reg, cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (sst_pkg::reg_idx_t'(cfg_index))
                sst_pkg::REG_START_STEP:   cfg_next.start_step   = cfg_data[30:0];
                sst_pkg::REG_TOP_STEP:     cfg_next.top_step     = cfg_data[30:0];
                sst_pkg::REG_BOTTOM_STEP:  cfg_next.bottom_step  = cfg_data[30:0];
                sst_pkg::REG_UP_RATIO:     cfg_next.up_ratio     = cfg_data[17:0];
                sst_pkg::REG_DOWN_RATIO:   cfg_next.down_ratio   = cfg_data[16:0];
                sst_pkg::REG_NOTE_LENGTH:  cfg_next.note_length  = cfg_data[15:0];
                sst_pkg::REG_VOLUME:       cfg_next.volume       = cfg_data[15:0];
                sst_pkg::REG_SWEEP_ENABLE: cfg_next.sweep_enable = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_step   <= sst_pkg::START_STEP_RST;
            cfg_reg.top_step     <= sst_pkg::TOP_STEP_RST;
            cfg_reg.bottom_step  <= sst_pkg::BOTTOM_STEP_RST;
            cfg_reg.up_ratio     <= sst_pkg::UP_RATIO_RST;
            cfg_reg.down_ratio   <= sst_pkg::DOWN_RATIO_RST;
            cfg_reg.note_length  <= sst_pkg::NOTE_LENGTH_RST;
            cfg_reg.volume       <= sst_pkg::VOLUME_RST;
            cfg_reg.sweep_enable <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/sst_mul.sv
// digit-serial shift-add multiplier, two multiplier bits per cycle
module sst_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  sst_pkg::mul_req_t req,
    output sst_pkg::mul_rsp_t rsp
);

    logic [sst_pkg::PROD_W-1:0] a_sh_reg, a_sh_next;
    logic [sst_pkg::MUL_W-1:0]  b_reg, b_next;
    logic [sst_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [sst_pkg::PROD_W-1:0] pp0, pp1;

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

    // partial products of the current 2-bit digit
    assign pp0 = b_reg[0] ? a_sh_reg : '0;
    assign pp1 = b_reg[1] ? {a_sh_reg[sst_pkg::PROD_W-2:0], 1'b0} : '0;

    // load, then accumulate until the remaining multiplier bits are zero
    always_comb begin
        a_sh_next = a_sh_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            a_sh_next = {{sst_pkg::MUL_W{1'b0}}, req.a};
            b_next    = req.b;
            acc_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next  = acc_reg + pp0 + pp1;
            a_sh_next = {a_sh_reg[sst_pkg::PROD_W-3:0], 2'b00};
            b_next    = {2'b00, b_reg[sst_pkg::MUL_W-1:2]};
            if (b_reg[sst_pkg::MUL_W-1:2] == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_sh_reg <= a_sh_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
    end

endmodule

### rtl/stepped_sweep_tone_generator_unit.sv
// top level of the stepped sweep tone generator
//
// Each request on the s_ channel is one sample tick; its only field is the
// last-tick flag in s_tdata bit 0. Every request yields exactly one result
// on the m_ channel: the signed Q1.15 sample, its unsigned 8-bit copy and the
// echoed last flag on m_tlast. Registers are written through the cfg_ port
// (index and data), one per cycle, and should only change while idle.
// The sample is volume * sin(2*pi*frac(step*index)); in sweep mode the step
// is scaled by the up or down ratio at every note boundary.
// All products (phase, five sine polynomial terms, volume, step scaling) run
// one after another on a single multiplier that retires two multiplier bits
// per cycle and stops as soon as the remaining bits are zero.
// One request is in work at a time. After reset the registers hold their
// defaults, the sample index is zero, the step is the start step and the
// sweep rises. A last tick restarts that state after its own sample. A
// finished result sits in the output register until taken; meanwhile the next
// request is accepted and computed and waits until the output register is free.
module stepped_sweep_tone_generator_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [0] last_tick
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,   // [15:0] sample, [23:16] sample_u8
    output logic                                m_tlast,   // last_out
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sst_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sst_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    typedef enum logic [7:0] {
        OP_PHASE = 8'b0000_0001,
        OP_X2    = 8'b0000_0010,
        OP_T1    = 8'b0000_0100,
        OP_T2    = 8'b0000_1000,
        OP_T3    = 8'b0001_0000,
        OP_Y     = 8'b0010_0000,
        OP_VOL   = 8'b0100_0000,
        OP_STEP  = 8'b1000_0000
    } op_t;

    sst_pkg::cfg_t     cfg;
    sst_pkg::mul_req_t mul_req;
    sst_pkg::mul_rsp_t mul_rsp;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    // per-sample state
    logic [31:0] sample_index_reg, sample_index_next;
    logic [31:0] phase_step_reg, phase_step_next;
    logic        sweep_up_reg, sweep_up_next;
    logic [15:0] note_count_reg, note_count_next;

    // working values
    logic                      last_reg, last_next;
    logic [1:0]                quad_reg, quad_next;
    logic [sst_pkg::X_W-1:0]   x_reg, x_next;
    logic [sst_pkg::X_W-1:0]   x2_reg, x2_next;
    logic [sst_pkg::X_W-1:0]   t_reg, t_next;
    logic [14:0]               mag_reg, mag_next;
    logic [15:0]               smp_reg, smp_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_sample_reg, m_sample_next;
    logic        m_last_reg, m_last_next;

    // combinational helpers
    logic [31:0]                    step_sel;
    logic [sst_pkg::SINE_ADDR_BITS-1:0] addr;
    logic [sst_pkg::SINE_ADDR_BITS-2:0] r_pos, r_mir;
    logic [sst_pkg::X_W-1:0]        p_hi;
    logic [17:0]                    y_inc;
    logic [16:0]                    y_half;
    logic [32:0]                    rnd;
    logic [17:0]                    p_rnd;
    logic [31:0]                    step_scaled;
    logic [16:0]                    nc_inc;
    logic                           out_free;

    sst_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sst_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    // ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {~m_sample_reg[15], m_sample_reg[14:8], m_sample_reg};
    assign m_tlast  = m_last_reg;
    assign out_free = !m_valid_reg || m_tready;

    // phase step used for this sample
    assign step_sel = cfg.sweep_enable ? phase_step_reg : {1'b0, cfg.start_step};

    // table address and mirrored quarter-wave position
    assign addr  = mul_rsp.p[sst_pkg::PHASE_BITS-1 -: sst_pkg::SINE_ADDR_BITS];
    assign r_pos = {1'b0, addr[sst_pkg::SINE_ADDR_BITS-3:0]};
    assign r_mir = addr[sst_pkg::SINE_ADDR_BITS-2] ? (sst_pkg::SINE_QUARTER - r_pos) : r_pos;

    // product shifted right by 16
    assign p_hi = mul_rsp.p[32:16];

    // Q15 magnitude from the Q16 sine
    assign y_inc  = {1'b0, p_hi} + 18'd1;
    assign y_half = y_inc[17:1];

    // volume scaling with round half away from zero on the magnitude
    assign rnd   = {1'b0, mul_rsp.p[31:0]} + 33'd16384;
    assign p_rnd = rnd[32:15];

    // scaled step, saturated to 32 bits
    assign step_scaled = (mul_rsp.p[63:48] != '0) ? 32'hFFFF_FFFF : mul_rsp.p[47:16];

    assign nc_inc = {1'b0, note_count_reg} + 17'd1;

    // multiplier operands per operation
    always_comb begin
        mul_req.start = (state_reg == ST_ISSUE);
        mul_req.a     = '0;
        mul_req.b     = '0;
        unique case (op_reg)
            OP_PHASE: begin
                mul_req.a = step_sel;
                mul_req.b = sample_index_reg;
            end
            OP_X2: begin
                mul_req.a = 32'(x_reg);
                mul_req.b = 32'(x_reg);
            end
            OP_T1: begin
                mul_req.a = 32'(x2_reg);
                mul_req.b = 32'(sst_pkg::SINE_C3);
            end
            OP_T2, OP_T3: begin
                mul_req.a = 32'(x2_reg);
                mul_req.b = 32'(t_reg);
            end
            OP_Y: begin
                mul_req.a = 32'(t_reg);
                mul_req.b = 32'(x_reg);
            end
            OP_VOL: begin
                mul_req.a = 32'(mag_reg);
                mul_req.b = 32'(cfg.volume);
            end
            OP_STEP: begin
                mul_req.a = phase_step_reg;
                mul_req.b = sweep_up_reg ? 32'(cfg.up_ratio) : 32'(cfg.down_ratio);
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next        = state_reg;
        op_next           = op_reg;
        sample_index_next = sample_index_reg;
        phase_step_next   = phase_step_reg;
        sweep_up_next     = sweep_up_reg;
        note_count_next   = note_count_reg;
        last_next         = last_reg;
        quad_next         = quad_reg;
        x_next            = x_reg;
        x2_next           = x2_reg;
        t_next            = t_reg;
        mag_next          = mag_reg;
        smp_next          = smp_reg;
        m_valid_next      = m_valid_reg;
        m_sample_next     = m_sample_reg;
        m_last_next       = m_last_reg;

        // result taken by the receiver
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    last_next  = s_tdata[0];
                    op_next    = OP_PHASE;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (mul_rsp.done) begin
                    state_next = ST_ISSUE;
                    unique case (op_reg)
                        OP_PHASE: begin
                            quad_next = addr[sst_pkg::SINE_ADDR_BITS-1 -: 2];
                            x_next    = {r_mir, {sst_pkg::X_SHIFT{1'b0}}};
                            op_next   = OP_X2;
                        end
                        OP_X2: begin
                            x2_next = p_hi;
                            op_next = OP_T1;
                        end
                        OP_T1: begin
                            t_next  = sst_pkg::SINE_C2 - p_hi;
                            op_next = OP_T2;
                        end
                        OP_T2: begin
                            t_next  = sst_pkg::SINE_C1 - p_hi;
                            op_next = OP_T3;
                        end
                        OP_T3: begin
                            t_next  = sst_pkg::SINE_C0 - p_hi;
                            op_next = OP_Y;
                        end
                        OP_Y: begin
                            mag_next = (y_half[16:15] != 2'b00) ? 15'h7FFF : y_half[14:0];
                            op_next  = OP_VOL;
                        end
                        OP_VOL: begin
                            // apply sign of the second half-turn and saturate
                            if (quad_reg[1]) begin
                                smp_next = (p_rnd > 18'd32768) ? 16'h8000
                                                               : (~p_rnd[15:0] + 16'd1);
                            end else begin
                                smp_next = (p_rnd > 18'd32767) ? 16'h7FFF : p_rnd[15:0];
                            end
                            // note boundary, never at index zero
                            if (cfg.sweep_enable && (sample_index_reg != '0)
                                    && (note_count_reg == '0)) begin
                                op_next = OP_STEP;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        OP_STEP: begin
                            phase_step_next = step_scaled;
                            if (sweep_up_reg) begin
                                if (step_scaled > {1'b0, cfg.top_step}) begin
                                    sweep_up_next = 1'b0;
                                end
                            end else begin
                                if (step_scaled < {1'b0, cfg.bottom_step}) begin
                                    sweep_up_next = 1'b1;
                                end
                            end
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_sample_next     = smp_reg;
                    m_last_next       = last_reg;
                    note_count_next   = (nc_inc >= {1'b0, cfg.note_length}) ? 16'd0
                                                                            : nc_inc[15:0];
                    sample_index_next = sample_index_reg + 32'd1;
                    // restart after a last tick
                    if (last_reg) begin
                        sample_index_next = '0;
                        phase_step_next   = {1'b0, cfg.start_step};
                        sweep_up_next     = 1'b1;
                        note_count_next   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            op_reg           <= OP_PHASE;
            sample_index_reg <= '0;
            phase_step_reg   <= {1'b0, sst_pkg::START_STEP_RST};
            sweep_up_reg     <= 1'b1;
            note_count_reg   <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            sample_index_reg <= sample_index_next;
            phase_step_reg   <= phase_step_next;
            sweep_up_reg     <= sweep_up_next;
            note_count_reg   <= note_count_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // working and output payload
    always_ff @(posedge aclk) begin
        last_reg     <= last_next;
        quad_reg     <= quad_next;
        x_reg        <= x_next;
        x2_reg       <= x2_next;
        t_reg        <= t_next;
        mag_reg      <= mag_next;
        smp_reg      <= smp_next;
        m_sample_reg <= m_sample_next;
        m_last_reg   <= m_last_next;
    end

endmodule
